// ===== rtl/source_text_tokenizer_defines.svh =====
// Assertion macros for the source text tokenizer checker.
// Included by the checker file; depends on nothing else.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define STT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled while rst is high.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/stt_pkg.sv =====
// Shared types, token codes and character classes for the source text tokenizer.
// Used by the lexer core, the result queue, the top level and the checker.
`timescale 1ns / 1ps

package stt_pkg;

   localparam int POSITION_BITS_DEFAULT     = 16;
   localparam int KEYWORD_MAX_CHARS_DEFAULT = 7;

   localparam int KIND_W = 5;
   localparam int OUT_W  = 16;
   localparam int CHAR_W = 8;

   localparam logic [KIND_W-1:0] KIND_EQUAL    = 5'd12;
   localparam logic [KIND_W-1:0] KIND_DEQUAL   = 5'd13;
   localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd14;
   localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd20;
   localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd21;
   localparam logic [KIND_W-1:0] KIND_END      = 5'd22;
   localparam logic [KIND_W-1:0] KIND_BAD      = 5'd23;

   localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

   localparam int NUM_PUNCT = 12;
   // Index into this table is the token kind of the punctuation mark.
   localparam logic [CHAR_W-1:0] PUNCT_CHARS [NUM_PUNCT] = '{
      8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h28, 8'h29,
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h2C
   };

   localparam int NUM_KEYWORDS = 6;
   localparam int KW_BYTES     = 8;
   // Keyword text with the first character in the low byte.
   localparam logic [8*KW_BYTES-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      64'h0065_6E69_6761_6D69,
      64'h0000_7265_6D6D_7562,
      64'h0000_0000_0000_6E66,
      64'h0065_736F_7070_7573,
      64'h0074_696B_6365_6863,
      64'h0000_0074_696D_6F76
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{4'd7, 4'd6, 4'd2, 4'd7, 4'd7, 4'd5};

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [OUT_W-1:0]  start_pos;
      logic [OUT_W-1:0]  token_len;
      logic [CHAR_W-1:0] bad_char;
      logic              run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } emit_type;

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
   endfunction

   function automatic logic is_punct(input logic [CHAR_W-1:0] c);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_PUNCT; i++) begin
         if (c == PUNCT_CHARS[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic [KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] k;
      k = '0;
      for (int i = 0; i < NUM_PUNCT; i++) begin
         if (c == PUNCT_CHARS[i]) begin
            k = KIND_W'(i);
         end
      end
      return k;
   endfunction

endpackage

// ===== rtl/stt_lex_core.sv =====
// Lexer state and per-character classification for the source text tokenizer.
// Produces up to two results per accepted character; depends on stt_pkg.
`timescale 1ns / 1ps

module stt_lex_core #(
   parameter int POSITION_BITS     = stt_pkg::POSITION_BITS_DEFAULT,
   parameter int KEYWORD_MAX_CHARS = stt_pkg::KEYWORD_MAX_CHARS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic [stt_pkg::CHAR_W-1:0] ch,
   output stt_pkg::emit_type          emit
);
   import stt_pkg::*;

   localparam int PW = POSITION_BITS;
   localparam int PREFIX_W = 8 * KEYWORD_MAX_CHARS;

   logic [PW-1:0]       position_ff, position_in;
   logic                in_word_ff, in_word_in;
   logic                has_letter_ff, has_letter_in;
   logic [PW-1:0]       word_start_ff, word_start_in;
   logic [PW-1:0]       word_len_ff, word_len_in;
   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic                pend_eq_ff, pend_eq_in;
   logic                error_ff, error_in;

   function automatic logic [OUT_W-1:0] to_out(input logic [PW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[OUT_W-1:0];
   endfunction

   function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
      return (v == '1) ? v : v + PW'(1);
   endfunction

   function automatic logic [KIND_W-1:0] word_kind(
      input logic                has_letter,
      input logic [PW-1:0]       len,
      input logic [PREFIX_W-1:0] prefix
   );
      logic [KIND_W-1:0] k;
      logic              same;
      k = KIND_IDENT;
      for (int j = NUM_KEYWORDS - 1; j >= 0; j--) begin
         same = (len == PW'(KW_LEN[j]));
         for (int i = 0; i < KEYWORD_MAX_CHARS; i++) begin
            if (i < int'(KW_LEN[j]) && prefix[8*i +: 8] != KW_TEXT[j][8*i +: 8]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            k = KIND_KEYWORD0 + KIND_W'(j);
         end
      end
      return has_letter ? k : KIND_NUMBER;
   endfunction

   result_type          flush_res, new_res, word_res, eq_res;
   logic                flush_vld, new_vld, flush_any;
   logic [PW-1:0]       len_base;
   logic [PREFIX_W-1:0] prefix_base;
   logic                letter_base;
   logic [1:0]          cnt;

   always_comb begin
      word_res = '{token_kind: word_kind(has_letter_ff, word_len_ff, prefix_ff),
                   start_pos: to_out(word_start_ff), token_len: to_out(word_len_ff),
                   bad_char: '0, run_last: 1'b0};
      eq_res   = '{token_kind: KIND_EQUAL, start_pos: to_out(word_start_ff),
                   token_len: 16'd1, bad_char: '0, run_last: 1'b0};
      flush_any = in_word_ff | pend_eq_ff;
      flush_res = in_word_ff ? word_res : eq_res;
      flush_vld = 1'b0;
      new_vld   = 1'b0;
      new_res   = '0;
      len_base    = word_len_ff;
      prefix_base = prefix_ff;
      letter_base = has_letter_ff;

      position_in   = position_ff;
      in_word_in    = in_word_ff;
      has_letter_in = has_letter_ff;
      word_start_in = word_start_ff;
      word_len_in   = word_len_ff;
      prefix_in     = prefix_ff;
      pend_eq_in    = pend_eq_ff;
      error_in      = error_ff;

      if (ch == CH_END) begin
         if (!error_ff) begin
            flush_vld = flush_any;
            new_vld   = 1'b1;
            new_res   = '{token_kind: KIND_END, start_pos: to_out(position_ff),
                          token_len: '0, bad_char: '0, run_last: 1'b0};
         end
         position_in   = '0;
         in_word_in    = 1'b0;
         has_letter_in = 1'b0;
         word_start_in = '0;
         word_len_in   = '0;
         prefix_in     = '0;
         pend_eq_in    = 1'b0;
         error_in      = 1'b0;
      end else if (error_ff) begin
         position_in = sat_inc(position_ff);
      end else if (pend_eq_ff && ch == CH_EQ) begin
         new_vld     = 1'b1;
         new_res     = '{token_kind: KIND_DEQUAL, start_pos: to_out(word_start_ff),
                         token_len: 16'd2, bad_char: '0, run_last: 1'b0};
         pend_eq_in  = 1'b0;
         position_in = sat_inc(position_ff);
      end else begin
         position_in = sat_inc(position_ff);
         if (is_letter(ch) || is_digit(ch)) begin
            if (pend_eq_ff) begin
               flush_vld  = 1'b1;
               pend_eq_in = 1'b0;
            end
            if (!in_word_ff) begin
               len_base      = '0;
               prefix_base   = '0;
               letter_base   = 1'b0;
               word_start_in = position_ff;
            end
            prefix_in = prefix_base;
            for (int i = 0; i < KEYWORD_MAX_CHARS; i++) begin
               if (len_base == PW'(i)) begin
                  prefix_in[8*i +: 8] = ch;
               end
            end
            in_word_in    = 1'b1;
            has_letter_in = letter_base | is_letter(ch);
            word_len_in   = sat_inc(len_base);
         end else begin
            flush_vld  = flush_any;
            in_word_in = 1'b0;
            pend_eq_in = 1'b0;
            if (is_space(ch)) begin
               new_vld = 1'b0;
            end else if (ch == CH_EQ) begin
               pend_eq_in    = 1'b1;
               word_start_in = position_ff;
            end else if (is_punct(ch)) begin
               new_vld = 1'b1;
               new_res = '{token_kind: punct_kind(ch), start_pos: to_out(position_ff),
                           token_len: 16'd1, bad_char: '0, run_last: 1'b0};
            end else begin
               new_vld  = 1'b1;
               new_res  = '{token_kind: KIND_BAD, start_pos: to_out(position_ff),
                            token_len: 16'd1, bad_char: ch, run_last: 1'b0};
               error_in = 1'b1;
            end
         end
      end

      cnt = 2'(flush_vld) + 2'(new_vld);
      emit.count  = take ? cnt : 2'd0;
      emit.first  = flush_vld ? flush_res : new_res;
      emit.second = new_res;
      emit.first.run_last  = (cnt == 2'd1);
      emit.second.run_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         in_word_ff    <= 1'b0;
         has_letter_ff <= 1'b0;
         word_start_ff <= '0;
         word_len_ff   <= '0;
         prefix_ff     <= '0;
         pend_eq_ff    <= 1'b0;
         error_ff      <= 1'b0;
      end else if (take) begin
         position_ff   <= position_in;
         in_word_ff    <= in_word_in;
         has_letter_ff <= has_letter_in;
         word_start_ff <= word_start_in;
         word_len_ff   <= word_len_in;
         prefix_ff     <= prefix_in;
         pend_eq_ff    <= pend_eq_in;
         error_ff      <= error_in;
      end
   end

endmodule

// ===== rtl/stt_rsp_queue.sv =====
// Three-entry result queue that takes up to two results a cycle and sends one while rsp_ready is high.
// Depends on stt_pkg for the result and push types.
`timescale 1ns / 1ps

module stt_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  stt_pkg::emit_type   push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stt_pkg::result_type head
);
   import stt_pkg::*;

   localparam int DEPTH = 3;
   localparam logic [1:0] LAST_SLOT = 2'(DEPTH - 1);

   result_type entries [DEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_next;
   logic       pop;

   function automatic logic [1:0] ptr_inc(input logic [1:0] p);
      return (p == LAST_SLOT) ? 2'd0 : p + 2'd1;
   endfunction

   assign wr_next   = ptr_inc(wr_ptr_ff);
   assign rsp_valid = (count_ff != 2'd0);
   assign room      = (count_ff < 2'd2);
   assign pop       = rsp_valid & rsp_ready;
   assign head      = entries[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + push.count - 2'(pop);
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      unique case (push.count)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_next;
         default: wr_ptr_in = ptr_inc(wr_next);
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Source text tokenizer: one character per transfer in, tokens out.
// A result is registered into the result queue and is shown once older ones are sent.
// Up to one character per cycle while the result queue has room; a character
// that makes two results holds the next back until the three-entry queue sends one.
// Synchronous active-high reset clears the lexer state and empties the queue.
// Depends on stt_pkg, stt_lex_core and stt_rsp_queue.
`timescale 1ns / 1ps

module source_text_tokenizer #(
   parameter int POSITION_BITS     = stt_pkg::POSITION_BITS_DEFAULT,
   parameter int KEYWORD_MAX_CHARS = stt_pkg::KEYWORD_MAX_CHARS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [stt_pkg::CHAR_W-1:0] req_ch,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [stt_pkg::KIND_W-1:0] rsp_token_kind,
   output logic [stt_pkg::OUT_W-1:0]  rsp_start_pos,
   output logic [stt_pkg::OUT_W-1:0]  rsp_token_len,
   output logic [stt_pkg::CHAR_W-1:0] rsp_bad_char,
   output logic                       rsp_run_last
);
   import stt_pkg::*;

   emit_type   emit;
   result_type head;
   logic       take;

   assign take = req_valid & req_ready;

   stt_lex_core #(
      .POSITION_BITS    (POSITION_BITS),
      .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .take (take),
      .ch   (req_ch),
      .emit (emit)
   );

   stt_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (emit),
      .room     (req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .head     (head)
   );

   assign rsp_token_kind = head.token_kind;
   assign rsp_start_pos  = head.start_pos;
   assign rsp_token_len  = head.token_len;
   assign rsp_bad_char   = head.bad_char;
   assign rsp_run_last   = head.run_last;

endmodule

// ===== rtl/stt_checker.sv =====
// Port-level checks for the source text tokenizer, bound to the top level.
// Depends on stt_pkg and source_text_tokenizer_defines.svh.
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module stt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [stt_pkg::KIND_W-1:0] rsp_token_kind,
   input logic [stt_pkg::OUT_W-1:0]  rsp_token_len,
   input logic [stt_pkg::CHAR_W-1:0] rsp_bad_char,
   input logic                       rsp_run_last
);
   import stt_pkg::*;

   `STT_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)
   `STT_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `STT_ASSERT_NOW(a_bad_char_only_on_error, clock, reset, rsp_valid && rsp_token_kind != KIND_BAD, rsp_bad_char == 8'd0)
   `STT_ASSERT_NOW(a_end_is_last, clock, reset, rsp_valid && rsp_token_kind == KIND_END, rsp_token_len == 16'd0 && rsp_run_last)

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
